[hdl/gsdd_pkg.sv]
// Shared types and constants for the goal-seek differential-drive controller.
// No dependencies.
`default_nettype none
package gsdd_pkg;
    localparam int ATAN_ENTRIES = 24;
    localparam int DEG180 = 46080;
    localparam int DEG360 = 92160;
    localparam int INV_K_Q16 = 39797;
    localparam int ANG_W = 20;

    typedef enum logic [2:0] {
        REG_STOP_DIST  = 3'd0,
        REG_REV_THRESH = 3'd1,
        REG_REV_HYST   = 3'd2,
        REG_DIST_GAIN  = 3'd3,
        REG_ANGLE_GAIN = 3'd4,
        REG_SPEED_LIM  = 3'd5,
        REG_TURN_LIM   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] stop_distance;
        logic [7:0]  reverse_threshold;
        logic [6:0]  reverse_hysteresis;
        logic [15:0] distance_gain;
        logic [15:0] angle_gain;
        logic [6:0]  speed_limit;
        logic [7:0]  turn_limit;
    } cfg_t;

    function automatic logic signed [ANG_W-1:0] atan_q8(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 20'sd11520;
                5'd1:  r = 20'sd6801;
                5'd2:  r = 20'sd3593;
                5'd3:  r = 20'sd1824;
                5'd4:  r = 20'sd916;
                5'd5:  r = 20'sd458;
                5'd6:  r = 20'sd229;
                5'd7:  r = 20'sd115;
                5'd8:  r = 20'sd57;
                5'd9:  r = 20'sd29;
                5'd10: r = 20'sd14;
                5'd11: r = 20'sd7;
                5'd12: r = 20'sd4;
                5'd13: r = 20'sd2;
                5'd14: r = 20'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

[hdl/gsdd_cordic.sv]
// Iterative vectoring CORDIC: one micro-rotation per cycle.
// Depends on gsdd_pkg.
`default_nettype none
module gsdd_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [COORD_BITS:0] dx,
    input  wire logic signed [COORD_BITS:0] dy,
    output logic done,
    output logic [COORD_BITS+9:0] mag,
    output logic signed [gsdd_pkg::ANG_W-1:0] angle
);
    localparam int XW = COORD_BITS + 11;
    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam int STEPS = (CORDIC_STEPS < gsdd_pkg::ATAN_ENTRIES) ?
        CORDIC_STEPS : gsdd_pkg::ATAN_ENTRIES;
    localparam logic signed [gsdd_pkg::ANG_W-1:0] ANG_W_C180 =
        gsdd_pkg::ANG_W'(gsdd_pkg::DEG180);

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [gsdd_pkg::ANG_W-1:0] z_reg, z_next;
    logic [SW-1:0] step_reg;
    logic busy_reg, done_reg;
    logic signed [XW-1:0] x0, y0;

    always_comb
    begin
        x0 = XW'(dx) <<< 8;
        y0 = XW'(dy) <<< 8;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        if (y_reg > 0)
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + gsdd_pkg::atan_q8(5'(step_reg));
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - gsdd_pkg::atan_q8(5'(step_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else
        begin
            done_reg <= start ? (dx == 0 && dy == 0)
                : (busy_reg && step_reg == SW'(STEPS - 1));
            if (start)
            begin
                step_reg <= '0;
                if (dx < 0)
                begin
                    x_reg <= -x0;
                    y_reg <= -y0;
                    z_reg <= (dy >= 0) ? ANG_W_C180 : -ANG_W_C180;
                end
                else
                begin
                    x_reg <= x0;
                    y_reg <= y0;
                    z_reg <= '0;
                end
                busy_reg <= (dx != 0 || dy != 0);
            end
            else if (busy_reg)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done  = done_reg;
    assign mag   = (COORD_BITS + 10)'(x_reg);
    assign angle = z_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg) else $error("done while busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < SW'(STEPS)) else $error("step overrun");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(start)) else $error("done held");
endmodule
`default_nettype wire

[hdl/goal_seek_diff_drive_top.sv]
// Top level of the goal-seek differential-drive controller.
// Depends on gsdd_pkg and gsdd_cordic.
`default_nettype none
// One pose transfer yields one wheel-command transfer. An item is loaded into
// the CORDIC, runs its micro-rotations in the shift-add unit, then passes
// through the S_DIST, S_ERR, S_VW and S_MIX states for gain removal, reverse
// decision, scaling and mixing. An item that reaches the goal finishes in
// S_DIST and skips the later states, and a zero vector skips the
// micro-rotations. The block takes one item at a time; a result waiting in the
// output register does not block the next input transfer, but a second finished
// result is held back and stalls the input until the first one transfers.
module goal_seek_diff_drive_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire logic [8:0] heading,
    input  wire logic [COORD_BITS-1:0] target_x,
    input  wire logic [COORD_BITS-1:0] target_y,
    output logic out_valid,
    input  wire logic out_ready,
    output logic signed [7:0] left_speed,
    output logic signed [7:0] right_speed,
    output logic goal_reached,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int MW = COORD_BITS + 10;
    localparam int AW = gsdd_pkg::ANG_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_DIST, S_ERR, S_VW, S_MIX
    } state_t;

    state_t state_reg;
    gsdd_pkg::cfg_t cfg_reg;
    logic reversing_reg;
    logic out_valid_reg, res_pending_reg;
    logic signed [7:0] left_reg, right_reg;
    logic goal_reg;
    logic signed [7:0] pend_left_reg, pend_right_reg;
    logic pend_goal_reg;
    logic [8:0] hd_reg;
    logic signed [COORD_BITS:0] dx_reg, dy_reg;
    logic cordic_start_reg;
    logic cordic_done;
    logic [MW-1:0] mag;
    logic signed [AW-1:0] angle;
    logic [MW+16:0] prod_reg;
    logic [MW-1:0] dist_reg;
    logic signed [AW-1:0] corr_reg;
    logic rev_reg;
    logic signed [47:0] v_reg, w_reg;

    gsdd_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_BITS(COORD_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start_reg),
        .dx(dx_reg), .dy(dy_reg), .done(cordic_done), .mag(mag), .angle(angle)
    );

    // Wrap, error and reverse decision
    logic signed [AW+1:0] t0, t1;
    logic signed [AW-1:0] err_c, aerr_c, corr_c;
    logic [17:0] enter_c, exit_c;
    logic signed [9:0] exitd;
    logic rev_c;
    always_comb
    begin
        t0 = (AW+2)'(angle) - (AW+2)'($signed({1'b0, hd_reg, 8'h00}))
            + (AW+2)'(gsdd_pkg::DEG180);
        t1 = t0;
        if (t1 < 0)
            t1 = t1 + (AW+2)'(gsdd_pkg::DEG360);
        if (t1 < 0)
            t1 = t1 + (AW+2)'(gsdd_pkg::DEG360);
        if (t1 >= (AW+2)'(gsdd_pkg::DEG360))
            t1 = t1 - (AW+2)'(gsdd_pkg::DEG360);
        err_c = AW'((AW+2)'(gsdd_pkg::DEG180) - t1);
        aerr_c = err_c < 0 ? -err_c : err_c;
        enter_c = {2'b0, (8'(cfg_reg.reverse_threshold) + 8'(0)) , 8'h00}
            + {3'b0, cfg_reg.reverse_hysteresis, 8'h00};
        exitd = $signed({2'b0, cfg_reg.reverse_threshold})
            - $signed({3'b0, cfg_reg.reverse_hysteresis});
        exit_c = exitd < 0 ? 18'd0 : {2'b0, exitd[7:0], 8'h00};
        if (!reversing_reg)
            rev_c = 18'(aerr_c) > enter_c;
        else
            rev_c = !(18'(aerr_c) < exit_c);
        corr_c = err_c;
        if (rev_c)
            corr_c = err_c > 0 ? err_c - AW'(gsdd_pkg::DEG180)
                : err_c + AW'(gsdd_pkg::DEG180);
    end

    // Clamp and mix
    logic signed [47:0] vlim, wlim, vc, wc, l17, r17, lim100;
    logic signed [47:0] lm, rm;
    always_comb
    begin
        vlim = 48'(cfg_reg.speed_limit) <<< 16;
        wlim = 48'(cfg_reg.turn_limit) <<< 16;
        vc = v_reg > vlim ? vlim : (v_reg < -vlim ? -vlim : v_reg);
        wc = w_reg > wlim ? wlim : (w_reg < -wlim ? -wlim : w_reg);
        lim100 = 48'sd100 <<< 17;
        l17 = 2 * vc - wc;
        r17 = 2 * vc + wc;
        l17 = l17 > lim100 ? lim100 : (l17 < -lim100 ? -lim100 : l17);
        r17 = r17 > lim100 ? lim100 : (r17 < -lim100 ? -lim100 : r17);
        lm = l17 < 0 ? -((-l17) >>> 17) : (l17 >>> 17);
        rm = r17 < 0 ? -((-r17) >>> 17) : (r17 >>> 17);
    end

    logic [MW+16:0] dist_full;
    assign dist_full = prod_reg + (MW+17)'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reversing_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_pending_reg <= 1'b0;
            cordic_start_reg <= 1'b0;
            left_reg <= '0;
            right_reg <= '0;
            goal_reg <= 1'b0;
            pend_left_reg <= '0;
            pend_right_reg <= '0;
            pend_goal_reg <= 1'b0;
            hd_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            prod_reg <= '0;
            dist_reg <= '0;
            corr_reg <= '0;
            rev_reg <= 1'b0;
            v_reg <= '0;
            w_reg <= '0;
            cfg_reg.stop_distance <= 12'd10;
            cfg_reg.reverse_threshold <= 8'd90;
            cfg_reg.reverse_hysteresis <= 7'd10;
            cfg_reg.distance_gain <= 16'd256;
            cfg_reg.angle_gain <= 16'd256;
            cfg_reg.speed_limit <= 7'd100;
            cfg_reg.turn_limit <= 8'd100;
        end
        else
        begin
            cordic_start_reg <= (state_reg == S_IDLE) && in_valid && in_ready;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gsdd_pkg::REG_STOP_DIST:  cfg_reg.stop_distance <= cfg_data[11:0];
                    gsdd_pkg::REG_REV_THRESH: cfg_reg.reverse_threshold <= cfg_data[7:0];
                    gsdd_pkg::REG_REV_HYST:   cfg_reg.reverse_hysteresis <= cfg_data[6:0];
                    gsdd_pkg::REG_DIST_GAIN:  cfg_reg.distance_gain <= cfg_data;
                    gsdd_pkg::REG_ANGLE_GAIN: cfg_reg.angle_gain <= cfg_data;
                    gsdd_pkg::REG_SPEED_LIM:  cfg_reg.speed_limit <= cfg_data[6:0];
                    gsdd_pkg::REG_TURN_LIM:   cfg_reg.turn_limit <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (res_pending_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                left_reg <= pend_left_reg;
                right_reg <= pend_right_reg;
                goal_reg <= pend_goal_reg;
                res_pending_reg <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        dx_reg <= $signed({1'b0, target_x}) - $signed({1'b0, pos_x});
                        dy_reg <= $signed({1'b0, target_y}) - $signed({1'b0, pos_y});
                        hd_reg <= heading;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (cordic_done)
                    begin
                        prod_reg <= (MW+17)'(mag) * (MW+17)'(gsdd_pkg::INV_K_Q16);
                        state_reg <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    dist_reg <= MW'(dist_full >> 16);
                    if ((dist_full >> 16) < (MW+17)'({cfg_reg.stop_distance, 8'h00}))
                    begin
                        pend_left_reg <= '0;
                        pend_right_reg <= '0;
                        pend_goal_reg <= 1'b1;
                        res_pending_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    corr_reg <= corr_c;
                    rev_reg <= rev_c;
                    reversing_reg <= rev_c;
                    state_reg <= S_VW;
                end
                S_VW:
                begin
                    v_reg <= rev_reg ? -(48'(cfg_reg.distance_gain) * 48'(dist_reg))
                        : 48'(cfg_reg.distance_gain) * 48'(dist_reg);
                    w_reg <= $signed({1'b0, cfg_reg.angle_gain}) * 48'(corr_reg);
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    pend_left_reg <= lm[7:0];
                    pend_right_reg <= rm[7:0];
                    pend_goal_reg <= 1'b0;
                    res_pending_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !res_pending_reg;
    assign out_valid = out_valid_reg;
    assign left_speed = left_reg;
    assign right_speed = right_reg;
    assign goal_reached = goal_reg;

    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_pending_reg |-> state_reg == S_IDLE) else $error("pending while busy");
    a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && goal_reached |-> left_speed == 0 && right_speed == 0)
        else $error("goal with speed");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_speed <= 100 && left_speed >= -100) else $error("range");
    a_dir_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_ERR |=> $stable(reversing_reg)) else $error("dir change");
endmodule
`default_nettype wire

[verif/tb_goal_seek_diff_drive_top.sv]
// Self-checking testbench for goal_seek_diff_drive_top: directed pose table, then random
// poses over several register settings, with wheel commands checked against a predictor.
// Depends on gsdd_pkg and the RTL under hdl/.
`default_nettype none
module tb_goal_seek_diff_drive_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic reached;
    } wheel_cmd_t;

    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        logic [8:0]  hd;
        logic [11:0] tx;
        logic [11:0] ty;
        bit          typed;
        wheel_cmd_t  cmd;
    } pose_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [11:0] pos_x = '0;
    logic [11:0] pos_y = '0;
    logic [8:0] heading = '0;
    logic [11:0] target_x = '0;
    logic [11:0] target_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic goal_reached;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    goal_seek_diff_drive_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .target_x(target_x), .target_y(target_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .left_speed(left_speed), .right_speed(right_speed), .goal_reached(goal_reached),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    longint atan_tbl[16] = '{11520, 6801, 3593, 1824, 916, 458, 229, 115,
                             57, 29, 14, 7, 4, 2, 1, 0};

    longint unsigned stop_d, rev_thr, rev_hyst, dist_gain, ang_gain, spd_lim, trn_lim;
    bit rev_mode;
    wheel_cmd_t cmd_q[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int reached_cnt = 0;
    int reverse_cnt = 0;
    int cycles = 0;
    bit hold_req = 1'b0;

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [7:0] to_wheel(input longint v);
        longint mag;
        mag = (v < 0 ? -v : v) >> 17;
        return 8'((v < 0) ? -mag : mag);
    endfunction

    function automatic wheel_cmd_t drive_command(input logic [11:0] px_i, input logic [11:0] py_i,
                                                 input logic [8:0] hd_i,
                                                 input logic [11:0] tx_i, input logic [11:0] ty_i);
        wheel_cmd_t c;
        longint dx, dy, x, y, z, xs, ys, dist_q8, t, err, aerr, corr, v, w, enter, exitv;
        dx = longint'(tx_i) - longint'(px_i);
        dy = longint'(ty_i) - longint'(py_i);
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? gsdd_pkg::DEG180 : -gsdd_pkg::DEG180;
        end
        if (dx != 0 || dy != 0) begin
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_tbl[i];
                end
                else begin
                    x -= ys; y += xs; z -= atan_tbl[i];
                end
            end
        end
        dist_q8 = (x * gsdd_pkg::INV_K_Q16 + 32768) >>> 16;
        if (dist_q8 < longint'(stop_d << 8)) begin
            c.left = 0; c.right = 0; c.reached = 1'b1;
            return c;
        end
        t = (z - longint'(hd_i) * 256 + gsdd_pkg::DEG180) % gsdd_pkg::DEG360;
        if (t < 0) t += gsdd_pkg::DEG360;
        err = -(t - gsdd_pkg::DEG180);
        aerr = err < 0 ? -err : err;
        enter = longint'(rev_thr + rev_hyst) * 256;
        exitv = longint'(rev_thr) - longint'(rev_hyst);
        if (exitv < 0) exitv = 0;
        exitv *= 256;
        if (!rev_mode) rev_mode = aerr > enter;
        else rev_mode = !(aerr < exitv);
        corr = err;
        if (rev_mode) corr = err > 0 ? err - gsdd_pkg::DEG180 : err + gsdd_pkg::DEG180;
        v = longint'(dist_gain) * dist_q8;
        if (rev_mode) v = -v;
        w = longint'(ang_gain) * corr;
        v = clamp_sym(v, longint'(spd_lim) << 16);
        w = clamp_sym(w, longint'(trn_lim) << 16);
        c.left = to_wheel(clamp_sym(2 * v - w, 100 <<< 17));
        c.right = to_wheel(clamp_sym(2 * v + w, 100 <<< 17));
        c.reached = 1'b0;
        return c;
    endfunction

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            gsdd_pkg::REG_STOP_DIST:  stop_d = data & 16'hFFF;
            gsdd_pkg::REG_REV_THRESH: rev_thr = data & 16'hFF;
            gsdd_pkg::REG_REV_HYST:   rev_hyst = data & 16'h7F;
            gsdd_pkg::REG_DIST_GAIN:  dist_gain = data;
            gsdd_pkg::REG_ANGLE_GAIN: ang_gain = data;
            gsdd_pkg::REG_SPEED_LIM:  spd_lim = data & 16'h7F;
            gsdd_pkg::REG_TURN_LIM:   trn_lim = data & 16'hFF;
            default: ;
        endcase
    endtask

    task automatic cfg_set(input logic [15:0] v0, input logic [15:0] v1, input logic [15:0] v2,
                           input logic [15:0] v3, input logic [15:0] v4, input logic [15:0] v5,
                           input logic [15:0] v6);
        cfg_write(gsdd_pkg::REG_STOP_DIST, v0);
        cfg_write(gsdd_pkg::REG_REV_THRESH, v1);
        cfg_write(gsdd_pkg::REG_REV_HYST, v2);
        cfg_write(gsdd_pkg::REG_DIST_GAIN, v3);
        cfg_write(gsdd_pkg::REG_ANGLE_GAIN, v4);
        cfg_write(gsdd_pkg::REG_SPEED_LIM, v5);
        cfg_write(gsdd_pkg::REG_TURN_LIM, v6);
        cfg_write(REG_UNUSED, 16'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender bursts: gap counts idle cycles before the next item.
    int burst_left = 0;
    task automatic send_pose(input pose_row_t r);
        wheel_cmd_t c;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                @(posedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
        end
        burst_left--;
        @(posedge clk);
        in_valid <= 1'b1;
        pos_x <= r.px; pos_y <= r.py; heading <= r.hd;
        target_x <= r.tx; target_y <= r.ty;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        c = drive_command(r.px, r.py, r.hd, r.tx, r.ty);
        if (r.typed && (c.left !== r.cmd.left || c.right !== r.cmd.right
                        || c.reached !== r.cmd.reached))
            report($sformatf("predictor disagrees with table row at item %0d", sent));
        if (r.typed) c = r.cmd;
        cmd_q.insert(cmd_q.size(), c);
        sent++;
    endtask

    task automatic idle_sender();
        @(posedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic pose_row_t random_pose();
        pose_row_t r;
        int span;
        r.tx = 12'($urandom);
        r.ty = 12'($urandom);
        case ($urandom_range(0, 3))
            0: span = 16;
            1: span = 300;
            2: span = 1500;
            default: span = 4096;
        endcase
        if (span == 4096) begin
            r.px = 12'($urandom);
            r.py = 12'($urandom);
        end
        else begin
            r.px = 12'(int'(r.tx) + $urandom_range(0, 2 * span) - span);
            r.py = 12'(int'(r.ty) + $urandom_range(0, 2 * span) - span);
        end
        r.hd = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                             : 9'($urandom_range(0, 359));
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic pose_row_t row(input int px, input int py, input int hd,
                                      input int tx, input int ty,
                                      input bit typed = 0, input int l = 0, input int rr = 0,
                                      input bit g = 0);
        pose_row_t r;
        r.px = 12'(px); r.py = 12'(py); r.hd = 9'(hd); r.tx = 12'(tx); r.ty = 12'(ty);
        r.typed = typed;
        r.cmd.left = 8'(l); r.cmd.right = 8'(rr); r.cmd.reached = g;
        return r;
    endfunction

    pose_row_t pose_table[$];

    initial begin
        pose_table = {
            row(100, 100, 0, 100, 100, 1, 0, 0, 1),
            row(0, 0, 0, 0, 0, 1, 0, 0, 1),
            row(4095, 4095, 359, 4095, 4095, 1, 0, 0, 1),
            row(2000, 2000, 45, 2005, 2005, 1, 0, 0, 1),
            row(0, 0, 0, 9, 0, 1, 0, 0, 1),
            row(0, 0, 0, 10, 0),
            row(0, 0, 0, 4095, 0),
            row(0, 0, 90, 0, 4095),
            row(4095, 0, 180, 0, 0),
            row(4095, 4095, 270, 0, 0),
            row(4095, 0, 180, 0, 4095),
            row(0, 4095, 359, 4095, 0),
            row(1000, 1000, 0, 900, 1000),
            row(1000, 1000, 180, 900, 1000),
            row(1000, 1000, 511, 1100, 1000),
            row(1000, 1000, 360, 1100, 1200),
            row(1000, 1000, 0, 1000, 900),
            row(1000, 1000, 0, 800, 900),
            row(1000, 1000, 45, 1100, 1100),
            row(1000, 1000, 270, 1100, 1100),
            row(2048, 2048, 256, 2047, 2047),
            row(0, 4095, 1, 4095, 4095)
        };
    end

    int rx_mode_left = 0;
    int rx_mode = 0;
    int hold_left = 0;
    always @(posedge clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 400;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(16, 96);
            end
            else rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(negedge clk) begin
        wheel_cmd_t c;
        if (rst_n && out_valid && out_ready) begin
            received++;
            if (cmd_q.size() == 0)
                report("wheel command transfer with none expected");
            else begin
                c = cmd_q.pop_front();
                if (goal_reached) reached_cnt++;
                if (!goal_reached && left_speed < 0 && right_speed < 0) reverse_cnt++;
                if (left_speed !== c.left)
                    report($sformatf("left_speed %0d, expected %0d", left_speed, c.left));
                if (right_speed !== c.right)
                    report($sformatf("right_speed %0d, expected %0d", right_speed, c.right));
                if (goal_reached !== c.reached)
                    report($sformatf("goal_reached %0b, expected %0b", goal_reached, c.reached));
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        stop_d = 10; rev_thr = 90; rev_hyst = 10; dist_gain = 256; ang_gain = 256;
        spd_lim = 100; trn_lim = 100; rev_mode = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (pose_table[i]) send_pose(pose_table[i]);
        repeat (200) send_pose(random_pose());
        idle_sender();
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: cfg_set(0, 0, 0, 0, 0, 0, 0);
                1: cfg_set(4095, 180, 90, 65535, 65535, 100, 200);
                2: cfg_set(3, 255, 127, 65535, 65535, 127, 255);
                3: cfg_set(10, 90, 10, 256, 256, 100, 100);
                4: cfg_set(0, 20, 60, 512, 64, 50, 30);
                default: cfg_set(16'($urandom_range(0, 60)), 16'($urandom_range(0, 180)),
                                 16'($urandom_range(0, 90)), 16'($urandom_range(0, 4096)),
                                 16'($urandom_range(0, 4096)), 16'($urandom_range(0, 100)),
                                 16'($urandom_range(0, 200)));
            endcase
            if (phase == 0) begin
                send_pose(row(500, 500, 0, 500, 500));
                send_pose(row(0, 0, 359, 0, 0));
            end
            if (phase == 2) hold_req = 1'b1;
            repeat (185) send_pose(random_pose());
            idle_sender();
            drain();
        end

        $display("Sent %0d poses over 9 register settings, %0d commands checked", sent, received);
        $display("Goal reached %0d times, both wheels reversed %0d times", reached_cnt,
                 reverse_cnt);
        if (errors == 0 && cmd_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
